/* rtl/core/esld_pkg.sv */
// Package with the parser state type, grammar codes and character helpers of the line detector.
package esld_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1b;
    localparam logic [7:0] CHAR_LB    = 8'h5b;
    localparam logic [7:0] CHAR_M     = 8'h6d;
    localparam logic [7:0] CHAR_SEMI  = 8'h3b;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [4:0] PREFIX_LEN = 5'd28;
    localparam logic [4:0] COUNT_MAX  = 5'd31;

    localparam logic [3:0] PH_PREFIX       = 4'd0;
    localparam logic [3:0] PH_SEP          = 4'd1;
    localparam logic [3:0] PH_OPEN_ESC     = 4'd2;
    localparam logic [3:0] PH_OPEN_LB      = 4'd3;
    localparam logic [3:0] PH_OPEN_PARAMS  = 4'd4;
    localparam logic [3:0] PH_BODY         = 4'd5;
    localparam logic [3:0] PH_CLOSE_LB     = 4'd6;
    localparam logic [3:0] PH_CLOSE_PARAMS = 4'd7;
    localparam logic [3:0] PH_TRAIL        = 4'd8;

    localparam logic [2:0] PM_NONE = 3'd0;
    localparam logic [2:0] PM_FIRST = 3'd1;
    localparam logic [2:0] PM_SECOND = 3'd2;
    localparam logic [2:0] PM_DEAD = 3'd7;

    localparam logic [1:0] OPEN_BASE  = 2'd0;
    localparam logic [1:0] CLOSE_BASE = 2'd2;

    typedef struct packed {
        logic [3:0] phase;
        logic [4:0] char_position;
        logic [2:0] param_match;
        logic       prefix_seen;
        logic       line_failed;
    } esld_state_t;

    localparam esld_state_t STATE_RESET = '{
        phase: PH_PREFIX, char_position: 5'd0, param_match: PM_NONE,
        prefix_seen: 1'b0, line_failed: 1'b0
    };

    function automatic logic is_numeral(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b inside {CHAR_SPACE, CHAR_TAB};
    endfunction

    // Timestamp shape dddd-dd-ddTdd:dd:dd.dddddddZ, where d is any decimal digit.
    function automatic logic stamp_ok(input logic [4:0] pos, input logic [7:0] b);
        logic ok;
        case (pos)
            5'd4, 5'd7:   ok = (b == 8'h2d);
            5'd10:        ok = (b == 8'h54);
            5'd13, 5'd16: ok = (b == 8'h3a);
            5'd19:        ok = (b == 8'h2e);
            5'd27:        ok = (b == 8'h5a);
            default:      ok = is_numeral(b);
        endcase
        return ok;
    endfunction

    // Candidates: 36;1 and 1;36 for the opener, 0 and 39 for the reset.
    function automatic logic [4:0] cand_len(input logic [1:0] idx);
        logic [4:0] len;
        case (idx)
            2'd0, 2'd1: len = 5'd4;
            2'd2:       len = 5'd1;
            default:    len = 5'd2;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cand_char(input logic [1:0] idx, input logic [1:0] pos);
        logic [7:0] c;
        case ({idx, pos})
            4'b00_00: c = 8'h33;
            4'b00_01: c = 8'h36;
            4'b00_10: c = CHAR_SEMI;
            4'b00_11: c = 8'h31;
            4'b01_00: c = 8'h31;
            4'b01_01: c = CHAR_SEMI;
            4'b01_10: c = 8'h33;
            4'b01_11: c = 8'h36;
            4'b10_00: c = 8'h30;
            4'b11_00: c = 8'h33;
            4'b11_01: c = 8'h39;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/esld_step.sv */
// Next-state and result logic of the line grammar for one accepted request.
module esld_step
    import esld_pkg::*;
(
    input  esld_state_t cur,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_line,
    output esld_state_t nxt,
    output logic        echoed_source,
    output logic        timestamp_prefix
);

    function automatic logic [1:0] cand_idx(input logic [1:0] base, input logic [2:0] pm);
        logic [1:0] sel;
        sel = pm[1:0] - 2'd1;
        return base + sel;
    endfunction

    function automatic logic [7:0] param_advance(input logic [1:0] base, input logic [2:0] pm,
                                                 input logic [4:0] cp, input logic [7:0] b);
        logic [1:0] idx;
        logic [2:0] pm_n;
        logic [4:0] cp_n;
        idx = cand_idx(base, pm);
        pm_n = pm;
        if (pm != PM_DEAD)
        begin
            if (pm == PM_NONE)
            begin
                if (cand_char(base, 2'd0) == b)
                    pm_n = PM_FIRST;
                else if (cand_char(base + 2'd1, 2'd0) == b)
                    pm_n = PM_SECOND;
                else
                    pm_n = PM_DEAD;
            end
            else if (!(cp < cand_len(idx) && cand_char(idx, cp[1:0]) == b))
            begin
                pm_n = PM_DEAD;
            end
        end
        cp_n = (cp < COUNT_MAX) ? cp + 5'd1 : cp;
        return {pm_n, cp_n};
    endfunction

    function automatic logic param_finish(input logic [1:0] base, input logic [2:0] pm,
                                          input logic [4:0] cp, input logic allow_empty);
        logic ok;
        if (pm == PM_NONE)
            ok = allow_empty;
        else if (pm == PM_DEAD)
            ok = 1'b0;
        else
            ok = (cp == cand_len(cand_idx(base, pm)));
        return ok;
    endfunction

    esld_state_t s;
    logic [4:0]  cp_inc;
    logic [1:0]  base;
    logic        allow_empty;

    always_comb
    begin
        s = cur;
        cp_inc = cur.char_position + 5'd1;
        base = (cur.phase == PH_CLOSE_PARAMS) ? CLOSE_BASE : OPEN_BASE;
        allow_empty = (cur.phase == PH_CLOSE_PARAMS);
        if (byte_present && !cur.line_failed)
        begin
            case (cur.phase)
                PH_PREFIX:
                begin
                    if (cur.char_position == 5'd0 && data_byte == ESC_BYTE)
                        s.phase = PH_OPEN_LB;
                    else if (!stamp_ok(cur.char_position, data_byte))
                        s.line_failed = 1'b1;
                    else if (cp_inc >= PREFIX_LEN)
                    begin
                        s.char_position = 5'd0;
                        s.phase = PH_SEP;
                    end
                    else
                        s.char_position = cp_inc;
                end
                PH_SEP:
                begin
                    if (is_blank(data_byte))
                    begin
                        s.prefix_seen = 1'b1;
                        s.phase = PH_OPEN_ESC;
                    end
                    else
                        s.line_failed = 1'b1;
                end
                PH_OPEN_ESC:
                begin
                    if (data_byte == ESC_BYTE)
                        s.phase = PH_OPEN_LB;
                    else
                        s.line_failed = 1'b1;
                end
                PH_OPEN_LB, PH_CLOSE_LB:
                begin
                    if (data_byte == CHAR_LB)
                    begin
                        s.phase = (cur.phase == PH_OPEN_LB) ? PH_OPEN_PARAMS : PH_CLOSE_PARAMS;
                        s.char_position = 5'd0;
                        s.param_match = PM_NONE;
                    end
                    else
                        s.line_failed = 1'b1;
                end
                PH_OPEN_PARAMS, PH_CLOSE_PARAMS:
                begin
                    if (is_numeral(data_byte) || data_byte == CHAR_SEMI)
                        {s.param_match, s.char_position} =
                            param_advance(base, cur.param_match, cur.char_position, data_byte);
                    else if (data_byte == CHAR_M &&
                             param_finish(base, cur.param_match, cur.char_position,
                                          allow_empty))
                        s.phase = (cur.phase == PH_OPEN_PARAMS) ? PH_BODY : PH_TRAIL;
                    else
                        s.line_failed = 1'b1;
                end
                PH_BODY:
                begin
                    if (data_byte == ESC_BYTE)
                        s.phase = PH_CLOSE_LB;
                end
                PH_TRAIL:
                begin
                    if (!(is_blank(data_byte) || data_byte == CHAR_CR || data_byte == CHAR_LF))
                        s.line_failed = 1'b1;
                end
                default:
                begin
                    s.line_failed = 1'b1;
                end
            endcase
        end
        echoed_source = !s.line_failed && (s.phase == PH_TRAIL);
        timestamp_prefix = s.prefix_seen || (!s.line_failed && s.phase == PH_SEP);
        nxt = end_of_line ? STATE_RESET : s;
    end

endmodule

/* rtl/core/echo_span_line_detector.sv */
// Top level of the echo-span line detector: parser state and result register.
//
// The block takes a log line one byte per request on the slave channel. s_tdata carries
// the byte, s_tuser says whether the byte is valid (clear for a bare end marker) and
// s_tlast closes the line. Only a request with s_tlast high yields a result on the
// master channel, where m_tdata bit 0 is the echoed-source answer and bit 1 the
// timestamp-prefix answer.
// Each request is parsed in the cycle it is accepted: the parser state registers and
// the result register are updated at the same edge, so a result appears on m_tvalid in
// the cycle after the closing request; while s_tready is high it accepts one request every
// cycle. The result register holds one result; s_tready falls only while that result
// waits and m_tready is low, so a stalled receiver stops the input and nothing is lost.
// Reset clears the parser to the start of a line and empties the result register.
// After a line is closed the parser returns to its reset state for the next line.
module echo_span_line_detector
    import esld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte [7:0]
    input  logic       s_tuser,   // byte_present
    input  logic       s_tlast,   // end_of_line
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // echoed_source [0], timestamp_prefix [1], zero [7:2]
);

    esld_state_t state_reg;
    esld_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [1:0]  result_reg;
    logic        echoed;
    logic        stamped;
    logic        take;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take = s_tvalid && s_tready;

    esld_step u_step (
        .cur              (state_reg),
        .data_byte        (s_tdata),
        .byte_present     (s_tuser),
        .end_of_line      (s_tlast),
        .nxt              (state_next),
        .echoed_source    (echoed),
        .timestamp_prefix (stamped)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (take && s_tlast)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (take)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
            result_reg <= {stamped, echoed};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {6'd0, result_reg};

endmodule

/* rtl/core/esld_checker.sv */
// Port-level checker of the echo-span line detector and its bind to the top level.
module esld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or was dropped.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while no result was waiting.");

    a_result_follows_close: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("Closing request gave no result.");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && s_tlast) && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("Result appeared without a closing request.");

endmodule

bind echo_span_line_detector esld_checker u_esld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
